[rtl/irb_pkg.sv]
// Shared types and constants for the image rotation block.
package irb_pkg;

  localparam int unsigned Q14_FRAC = 14;
  localparam int unsigned OUT_LIMIT = 1024;
  localparam int unsigned GEO_W = 11;
  localparam int unsigned SCAN_W = 10;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_COS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd3;

  localparam logic FUNC_LOAD = 1'b0;

  typedef enum logic [4:0] {
    ST_IDLE, ST_GEO0, ST_GEO1, ST_GEO2, ST_GEO3, ST_GEO4, ST_GEO5, ST_GEO6,
    ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_ADD, ST_CHK,
    ST_TAP0, ST_TAP1, ST_TAP2, ST_TAP3, ST_ACC, ST_OUT
  } irb_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_GEO0, OP_GEO1, OP_GEO2, OP_GEO3, OP_GEO4, OP_GEO5,
    OP_GEO6, OP_MUL0, OP_MUL1, OP_MUL2, OP_MUL3, OP_ADD, OP_CHK,
    OP_TAP0, OP_TAP1, OP_TAP2, OP_TAP3, OP_ACC, OP_OUT
  } irb_op_e;

  typedef struct packed {
    irb_op_e op;
  } irb_cmd_t;

  typedef struct packed {
    logic empty;
    logic in_src;
  } irb_sts_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } irb_cfg_t;

endpackage

[rtl/irb_in_if.sv]
// Input item channel: load or request items.
interface irb_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [8:0] load_row;
  logic [8:0] load_col;
  logic [7:0] load_value;

  modport source (output valid, func, load_row, load_col, load_value, input ready);
  modport sink (input valid, func, load_row, load_col, load_value, output ready);
endinterface

[rtl/irb_out_if.sv]
// Result item channel: rotated pixels.
interface irb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_value;
  logic [9:0]  out_row;
  logic [9:0]  out_col;
  logic        inside_res;
  logic        frame_last;
  logic [10:0] out_height;
  logic [10:0] out_width;

  modport source (output valid, pixel_value, out_row, out_col, inside_res, frame_last,
                  out_height, out_width, input ready);
  modport sink (input valid, pixel_value, out_row, out_col, inside_res, frame_last,
                out_height, out_width, output ready);
endinterface

[rtl/irb_ctrl.sv]
// Sequencer for load, geometry and per-pixel steps.
module irb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_func_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  irb_pkg::irb_sts_t sts_i,
  output irb_pkg::irb_cmd_t cmd_o
);
  import irb_pkg::*;

  irb_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire, out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_func_i == FUNC_LOAD) state_d = ST_GEO0;
          else if (!sts_i.empty) state_d = ST_MUL0;
        end
      end
      ST_GEO0: state_d = ST_GEO1;
      ST_GEO1: state_d = ST_GEO2;
      ST_GEO2: state_d = ST_GEO3;
      ST_GEO3: state_d = ST_GEO4;
      ST_GEO4: state_d = ST_GEO5;
      ST_GEO5: state_d = ST_GEO6;
      ST_GEO6: state_d = ST_IDLE;
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_ADD;
      ST_ADD:  state_d = ST_CHK;
      ST_CHK:  state_d = sts_i.in_src ? ST_TAP0 : ST_OUT;
      ST_TAP0: state_d = ST_TAP1;
      ST_TAP1: state_d = ST_TAP2;
      ST_TAP2: state_d = ST_TAP3;
      ST_TAP3: state_d = ST_ACC;
      ST_ACC:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_func_i == FUNC_LOAD) cmd_o.op = OP_LOAD;
      end
      ST_GEO0: cmd_o.op = OP_GEO0;
      ST_GEO1: cmd_o.op = OP_GEO1;
      ST_GEO2: cmd_o.op = OP_GEO2;
      ST_GEO3: cmd_o.op = OP_GEO3;
      ST_GEO4: cmd_o.op = OP_GEO4;
      ST_GEO5: cmd_o.op = OP_GEO5;
      ST_GEO6: cmd_o.op = OP_GEO6;
      ST_MUL0: cmd_o.op = OP_MUL0;
      ST_MUL1: cmd_o.op = OP_MUL1;
      ST_MUL2: cmd_o.op = OP_MUL2;
      ST_MUL3: cmd_o.op = OP_MUL3;
      ST_ADD:  cmd_o.op = OP_ADD;
      ST_CHK:  cmd_o.op = OP_CHK;
      ST_TAP0: cmd_o.op = OP_TAP0;
      ST_TAP1: cmd_o.op = OP_TAP1;
      ST_TAP2: cmd_o.op = OP_TAP2;
      ST_TAP3: cmd_o.op = OP_TAP3;
      ST_ACC:  cmd_o.op = OP_ACC;
      ST_OUT: begin
        if (out_free) cmd_o.op = OP_OUT;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == OP_OUT) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_geo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_func_i == FUNC_LOAD) |=> state_q == ST_GEO0)
    else $error("load item did not start geometry");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("waiting result dropped");
  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && !out_ready_i) |=> state_q == ST_OUT)
    else $error("result overwrote a waiting one");
  a_outside_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK && !sts_i.in_src) |=> state_q == ST_OUT)
    else $error("outside point went to taps");
endmodule

[rtl/irb_datapath.sv]
// Frame store, geometry registers, shared multiplier and interpolation datapath.
module irb_datapath #(
  parameter int unsigned MAX_ROWS = 512,
  parameter int unsigned MAX_COLS = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  irb_pkg::irb_cfg_t cfg_i,
  input  irb_pkg::irb_cmd_t cmd_i,
  output irb_pkg::irb_sts_t sts_o,
  input  logic [8:0]        load_row_i,
  input  logic [8:0]        load_col_i,
  input  logic [7:0]        load_value_i,
  output logic [7:0]        pixel_value_o,
  output logic [9:0]        out_row_o,
  output logic [9:0]        out_col_o,
  output logic              inside_res_o,
  output logic              frame_last_o,
  output logic [10:0]       out_height_o,
  output logic [10:0]       out_width_o
);
  import irb_pkg::*;

  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned MW = (RW > CW) ? RW : CW;
  localparam int unsigned GS = MW + 18;
  localparam int unsigned OFW = GS - Q14_FRAC;
  localparam int unsigned IW = ((OFW > SCAN_W) ? OFW : SCAN_W) + 1;
  localparam int unsigned BW = (IW > MW + 1) ? IW : MW + 1;
  localparam int unsigned MP = 17 + BW;
  localparam int unsigned PX = IW + 18;
  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned AC = 38;
  localparam logic [AW-1:0] NCOLS = AW'(MAX_COLS);
  localparam logic signed [GS-1:0] HALF_Q14 = GS'(8192);
  localparam logic [AC-1:0] HALF_Q28 = AC'(64'd1 << 27);

  // configuration and geometry
  logic [15:0]       cos_q, sin_q;
  logic [9:0]        rows_q, cols_q;
  logic [GEO_W-1:0]  h_q, w_q;
  logic [OFW-1:0]    roff_q, coff_q;
  logic [SCAN_W-1:0] srow_q, scol_q;

  logic signed [GS-1:0] bx_q, by_q, cx_q, cy_q, dx_q, dy_q;
  logic signed [GS-1:0] ah1_q, ah2_q, aw1_q, aw2_q, mx_q, my_q;
  logic signed [PX-1:0] t0_q, t1_q, t2_q, t3_q, px_q, py_q;
  logic                 inside_q;
  logic [RW-1:0]        x0_q, x1_q;
  logic [CW-1:0]        y0_q, y1_q;
  logic [13:0]          fx_q, fy_q;
  logic [7:0]           rd_q;
  logic [29:0]          wt_q;
  logic [AC-1:0]        acc_q;

  logic [7:0] mem [DEPTH];

  // effective sizes minus one
  logic [RW-1:0] rm;
  logic [CW-1:0] cm;
  always_comb begin
    if (rows_q == '0) rm = '0;
    else if (13'(rows_q) > 13'(MAX_ROWS)) rm = RW'(MAX_ROWS - 1);
    else rm = RW'(rows_q - 10'd1);
    if (cols_q == '0) cm = '0;
    else if (13'(cols_q) > 13'(MAX_COLS)) cm = CW'(MAX_COLS - 1);
    else cm = CW'(cols_q - 10'd1);
  end

  logic signed [IW-1:0] i_s, j_s;
  assign i_s = $signed({{(IW-SCAN_W){1'b0}}, srow_q}) - $signed({{(IW-OFW){1'b0}}, roff_q});
  assign j_s = $signed({{(IW-SCAN_W){1'b0}}, scol_q}) - $signed({{(IW-OFW){1'b0}}, coff_q});

  logic signed [16:0]    cos_a, sin_a;
  logic signed [BW-1:0]  rm_b, cm_b;
  logic signed [16:0]    mul_a;
  logic signed [BW-1:0]  mul_b;
  logic signed [MP-1:0]  mul_p;
  assign cos_a = 17'($signed(cos_q));
  assign sin_a = 17'($signed(sin_q));
  assign rm_b  = $signed({{(BW-RW){1'b0}}, rm});
  assign cm_b  = $signed({{(BW-CW){1'b0}}, cm});

  always_comb begin
    mul_a = cos_a;
    mul_b = BW'(i_s);
    case (cmd_i.op)
      OP_GEO0: begin mul_a = sin_a;  mul_b = cm_b; end
      OP_GEO1: begin mul_a = cos_a;  mul_b = cm_b; end
      OP_GEO2: begin mul_a = cos_a;  mul_b = rm_b; end
      OP_GEO3: begin mul_a = -sin_a; mul_b = rm_b; end
      OP_MUL0: begin mul_a = cos_a;  mul_b = BW'(i_s); end
      OP_MUL1: begin mul_a = sin_a;  mul_b = BW'(j_s); end
      OP_MUL2: begin mul_a = sin_a;  mul_b = BW'(i_s); end
      OP_MUL3: begin mul_a = cos_a;  mul_b = BW'(j_s); end
      default: begin mul_a = cos_a;  mul_b = BW'(i_s); end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // geometry helpers
  logic signed [GS-1:0] dxy_b, dxy_w, mx_c, my_c;
  assign dxy_b = bx_q - cx_q;
  assign dxy_w = by_q - cy_q;
  always_comb begin
    mx_c = '0;
    if (bx_q < mx_c) mx_c = bx_q;
    if (cx_q < mx_c) mx_c = cx_q;
    if (dx_q < mx_c) mx_c = dx_q;
    my_c = '0;
    if (by_q < my_c) my_c = by_q;
    if (cy_q < my_c) my_c = cy_q;
    if (dy_q < my_c) my_c = dy_q;
  end

  function automatic logic [GEO_W-1:0] round_span(input logic signed [GS-1:0] m);
    logic signed [GS-1:0] r;
    r = (m + HALF_Q14) >>> Q14_FRAC;
    if (r > GS'(OUT_LIMIT)) round_span = GEO_W'(OUT_LIMIT);
    else round_span = r[GEO_W-1:0];
  endfunction

  logic signed [GS-1:0] hmax, wmax, nmx, nmy;
  assign hmax = (ah1_q > ah2_q) ? ah1_q : ah2_q;
  assign wmax = (aw1_q > aw2_q) ? aw1_q : aw2_q;
  assign nmx  = -mx_q;
  assign nmy  = -my_q;

  // inside test
  logic signed [PX-1:0] rlim, clim;
  logic                 inside_c;
  assign rlim = $signed({{(PX-RW-Q14_FRAC){1'b0}}, rm, 14'd0});
  assign clim = $signed({{(PX-CW-Q14_FRAC){1'b0}}, cm, 14'd0});
  assign inside_c = (px_q >= 0) && (px_q <= rlim) && (py_q >= 0) && (py_q <= clim);

  // tap select: bit 0 picks x1, bit 1 picks y1
  logic [1:0]    tsel;
  logic          tap_rd;
  logic [RW-1:0] tx;
  logic [CW-1:0] ty;
  logic [14:0]   gx, gy, wx, wy;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  always_comb begin
    tsel   = 2'd0;
    tap_rd = 1'b1;
    case (cmd_i.op)
      OP_TAP0: tsel = 2'd0;
      OP_TAP1: tsel = 2'd1;
      OP_TAP2: tsel = 2'd2;
      OP_TAP3: tsel = 2'd3;
      default: tap_rd = 1'b0;
    endcase
  end
  assign gx = 15'd16384 - {1'b0, fx_q};
  assign gy = 15'd16384 - {1'b0, fy_q};
  assign tx = tsel[0] ? x1_q : x0_q;
  assign ty = tsel[1] ? y1_q : y0_q;
  assign wx = tsel[0] ? {1'b0, fx_q} : gx;
  assign wy = tsel[1] ? {1'b0, fy_q} : gy;
  assign rd_addr = AW'(tx) * NCOLS + AW'(ty);
  assign wr_addr = AW'(load_row_i) * NCOLS + AW'(load_col_i);
  assign wr_en   = (cmd_i.op == OP_LOAD) && (13'(load_row_i) < 13'(MAX_ROWS))
                   && (13'(load_col_i) < 13'(MAX_COLS));

  logic [AC-1:0] term, rnd;
  logic [9:0]    val_c;
  assign term  = AC'(rd_q) * AC'(wt_q);
  assign rnd   = acc_q + HALF_Q28;
  assign val_c = rnd[AC-1:28];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= load_value_i;
    if (tap_rd) rd_q <= mem[rd_addr];
  end

  assign sts_o.empty  = (h_q == '0) || (w_q == '0);
  assign sts_o.in_src = inside_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q  <= 16'd16384;
      sin_q  <= 16'd0;
      rows_q <= 10'd512;
      cols_q <= 10'd512;
      h_q    <= '0;
      w_q    <= '0;
      roff_q <= '0;
      coff_q <= '0;
      srow_q <= '0;
      scol_q <= '0;
    end else begin
      if (cfg_i.we) begin
        case (cfg_i.idx)
          CFG_COS:  cos_q  <= cfg_i.data;
          CFG_SIN:  sin_q  <= cfg_i.data;
          CFG_ROWS: rows_q <= cfg_i.data[9:0];
          CFG_COLS: cols_q <= cfg_i.data[9:0];
          default:  ;
        endcase
      end
      case (cmd_i.op)
        OP_LOAD: begin
          srow_q <= '0;
          scol_q <= '0;
        end
        OP_GEO6: begin
          h_q    <= round_span(hmax);
          w_q    <= round_span(wmax);
          roff_q <= nmx[GS-1:Q14_FRAC];
          coff_q <= nmy[GS-1:Q14_FRAC];
        end
        OP_OUT: begin
          if ({1'b0, scol_q} + 11'd1 < w_q) begin
            scol_q <= scol_q + 10'd1;
          end else begin
            scol_q <= '0;
            if ({1'b0, srow_q} + 11'd1 < h_q) srow_q <= srow_q + 10'd1;
            else srow_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_GEO0: bx_q <= GS'(mul_p);
      OP_GEO1: by_q <= GS'(mul_p);
      OP_GEO2: cx_q <= GS'(mul_p);
      OP_GEO3: cy_q <= GS'(mul_p);
      OP_GEO4: begin
        dx_q <= bx_q + cx_q;
        dy_q <= by_q + cy_q;
      end
      OP_GEO5: begin
        ah1_q <= (dxy_b < 0) ? -dxy_b : dxy_b;
        ah2_q <= (dx_q < 0) ? -dx_q : dx_q;
        aw1_q <= (dxy_w < 0) ? -dxy_w : dxy_w;
        aw2_q <= (dy_q < 0) ? -dy_q : dy_q;
        mx_q  <= mx_c;
        my_q  <= my_c;
      end
      OP_MUL0: t0_q <= PX'(mul_p);
      OP_MUL1: t1_q <= PX'(mul_p);
      OP_MUL2: t2_q <= PX'(mul_p);
      OP_MUL3: t3_q <= PX'(mul_p);
      OP_ADD: begin
        px_q <= t0_q - t1_q;
        py_q <= t2_q + t3_q;
      end
      OP_CHK: begin
        inside_q <= inside_c;
        x0_q <= px_q[RW+13:14];
        y0_q <= py_q[CW+13:14];
        x1_q <= px_q[RW+13:14] + RW'(px_q[13:0] != '0);
        y1_q <= py_q[CW+13:14] + CW'(py_q[13:0] != '0);
        fx_q <= px_q[13:0];
        fy_q <= py_q[13:0];
      end
      OP_TAP0: begin
        wt_q  <= wx * wy;
        acc_q <= '0;
      end
      OP_TAP1, OP_TAP2, OP_TAP3: begin
        wt_q  <= wx * wy;
        acc_q <= acc_q + term;
      end
      OP_ACC: acc_q <= acc_q + term;
      OP_OUT: begin
        if (!inside_q) pixel_value_o <= '0;
        else if (val_c > 10'd255) pixel_value_o <= 8'd255;
        else pixel_value_o <= val_c[7:0];
        out_row_o    <= srow_q;
        out_col_o    <= scol_q;
        inside_res_o <= inside_q;
        frame_last_o <= ({1'b0, srow_q} == h_q - 11'd1) && ({1'b0, scol_q} == w_q - 11'd1);
        out_height_o <= h_q;
        out_width_o  <= w_q;
      end
      default: ;
    endcase
  end
endmodule

[rtl/image_rotate_bilinear.sv]
// Top level of the bilinear image rotation block.
// Load items (func 0) write one gray pixel into the frame store and then run a
// 7-step geometry pass that uses the shared multiplier; the scan restarts at
// (0,0). Request items (func 1) take four steps on the shared 17-bit multiplier
// for the inverse rotation and, when the mapped point lies inside the source,
// then four reads of the single-port frame store, one per bilinear tap; while
// the output size is zero they are taken and dropped. A finished pixel waits
// in the output register while the next item is taken. Register writes affect
// requests at once and the geometry at the next load. The frame store needs
// no clearing pass; entries must be loaded before they are read.
module image_rotate_bilinear #(
  parameter int unsigned MAX_ROWS = 512,
  parameter int unsigned MAX_COLS = 512
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  irb_in_if.sink                             in_s,
  irb_out_if.source                          out_s,
  input  logic                               cfg_we_i,
  input  logic [irb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [irb_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import irb_pkg::*;

  irb_cfg_t cfg;
  irb_cmd_t cmd;
  irb_sts_t sts;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  irb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .in_func_i   (in_s.func),
    .in_ready_o  (in_s.ready),
    .out_valid_o (out_s.valid),
    .out_ready_i (out_s.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  irb_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .load_row_i    (in_s.load_row),
    .load_col_i    (in_s.load_col),
    .load_value_i  (in_s.load_value),
    .pixel_value_o (out_s.pixel_value),
    .out_row_o     (out_s.out_row),
    .out_col_o     (out_s.out_col),
    .inside_res_o  (out_s.inside_res),
    .frame_last_o  (out_s.frame_last),
    .out_height_o  (out_s.out_height),
    .out_width_o   (out_s.out_width)
  );
endmodule
